// File: rtl/pfe_pkg.sv
// Package for the potential-field evaluator: shared widths, register codes,
// reset values and the pipeline control struct. It depends on nothing.
package pfe_pkg;

	localparam int COORD_BITS_DEF = 12;
	localparam int FRAC_BITS_DEF  = 8;
	localparam int RECIP_BITS     = 24;
	localparam int GAIN_W         = 16;
	localparam int ATT_SHIFT      = 12;
	localparam int OUT_W          = 28;
	localparam int LANES          = 2;
	localparam int CFG_IDX_W      = 3;

	localparam logic [OUT_W-1:0] OUT_MAX = '1;

	localparam int RST_GOAL_X     = 400;
	localparam int RST_GOAL_Y     = 500;
	localparam int RST_OBST_X     = 1000;
	localparam int RST_OBST_Y     = 300;
	localparam int RST_ATT_GAIN   = 410;
	localparam int RST_REP_GAIN   = 1000;
	localparam int RST_RADIUS     = 300;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_GOAL_X   = 3'd0,
		REG_GOAL_Y   = 3'd1,
		REG_OBST_X   = 3'd2,
		REG_OBST_Y   = 3'd3,
		REG_ATT_GAIN = 3'd4,
		REG_REP_GAIN = 3'd5,
		REG_RADIUS   = 3'd6
	} cfg_reg_t;

	// Pipeline control handed to each arithmetic unit.
	typedef struct packed {
		logic adv;
		logic valid;
	} pipe_ctl_t;

endpackage

// File: rtl/potential_field_evaluator.sv
// Top level of the potential-field evaluator: configuration registers and
// the full evaluation pipeline. Depends on pfe_pkg, pfe_sqrt and pfe_div.
//
// Usage: each input beat on (in_valid, in_stall) carries one grid point
// (point_x, point_y). Each point yields exactly one output beat on
// (out_valid, out_stall) with the attractive, repulsive and total potential,
// all times ten in unsigned Q20.8 and saturated to 28 bits, plus a flag that
// is set when the point sits on the obstacle inside its influence radius.
// Goal, obstacle, gains and radius are written through cfg_write, cfg_index
// and cfg_data while no point is in flight; unknown indexes are ignored.
// The pipeline runs through two front stages, one stage per root bit in the
// square root, one stage per quotient bit in the reciprocal divider, then
// multiply and output stages. It takes one point per cycle unless out_stall
// holds a valid result at the output.
// The whole pipeline advances together. When out_stall holds a valid result,
// every stage freezes and in_stall is raised in the same cycle, so nothing
// is lost or repeated; bubbles still move forward while the output is empty.
// Reset clears all valid bits and loads the default configuration; no
// clearing pass is needed, so points are taken right after reset.
module potential_field_evaluator #(
	parameter int COORD_BITS = pfe_pkg::COORD_BITS_DEF,
	parameter int FRAC_BITS  = pfe_pkg::FRAC_BITS_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_stall,
	input  logic [COORD_BITS-1:0]       point_x,
	input  logic [COORD_BITS-1:0]       point_y,
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic [pfe_pkg::OUT_W-1:0]   attract_value,
	output logic [pfe_pkg::OUT_W-1:0]   repulse_value,
	output logic [pfe_pkg::OUT_W-1:0]   total_value,
	output logic                        repulse_infinite,
	input  logic                        cfg_write,
	input  logic [pfe_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [((COORD_BITS > pfe_pkg::GAIN_W) ? COORD_BITS : pfe_pkg::GAIN_W)-1:0] cfg_data
);

	localparam int CW      = COORD_BITS;
	localparam int F       = FRAC_BITS;
	localparam int GW      = pfe_pkg::GAIN_W;
	localparam int OW      = pfe_pkg::OUT_W;
	localparam int SW      = 2*CW + 1;              // dx^2 + dy^2
	localparam int NB      = CW + F + 1;            // distance in Q.F
	localparam int RW      = 2*NB;                  // square-root radicand
	localparam int QB      = F + pfe_pkg::RECIP_BITS + 1;
	localparam int DIFF_W  = F + pfe_pkg::RECIP_BITS;
	localparam int SQ_W    = 2*DIFF_W;
	localparam int K_W     = GW + 3;                // five times a gain
	localparam int P_W     = K_W + DIFF_W;
	localparam int ACC_W   = K_W + SQ_W;
	localparam int REP_SH  = 2*pfe_pkg::RECIP_BITS - F;
	localparam int ATT_W   = K_W + NB;
	localparam int ATT_X   = ATT_W + OW;
	localparam int SIDE_W  = OW + 2;

	// Configuration registers.
	logic [CW-1:0] goal_x_q, goal_y_q, obst_x_q, obst_y_q, radius_q;
	logic [GW-1:0] att_gain_q, rep_gain_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			goal_x_q   <= CW'(pfe_pkg::RST_GOAL_X);
			goal_y_q   <= CW'(pfe_pkg::RST_GOAL_Y);
			obst_x_q   <= CW'(pfe_pkg::RST_OBST_X);
			obst_y_q   <= CW'(pfe_pkg::RST_OBST_Y);
			att_gain_q <= GW'(pfe_pkg::RST_ATT_GAIN);
			rep_gain_q <= GW'(pfe_pkg::RST_REP_GAIN);
			radius_q   <= CW'(pfe_pkg::RST_RADIUS);
		end else if (cfg_write) begin
			unique case (pfe_pkg::cfg_reg_t'(cfg_index))
				pfe_pkg::REG_GOAL_X:   goal_x_q   <= cfg_data[CW-1:0];
				pfe_pkg::REG_GOAL_Y:   goal_y_q   <= cfg_data[CW-1:0];
				pfe_pkg::REG_OBST_X:   obst_x_q   <= cfg_data[CW-1:0];
				pfe_pkg::REG_OBST_Y:   obst_y_q   <= cfg_data[CW-1:0];
				pfe_pkg::REG_ATT_GAIN: att_gain_q <= cfg_data[GW-1:0];
				pfe_pkg::REG_REP_GAIN: rep_gain_q <= cfg_data[GW-1:0];
				pfe_pkg::REG_RADIUS:   radius_q   <= cfg_data[CW-1:0];
				default: ;
			endcase
		end
	end

	// Gains times five, and the radius in the same Q.F format as distances.
	logic [K_W-1:0] k_att, k_rep;
	logic [NB-1:0]  rq;

	assign k_att = K_W'({att_gain_q, 2'b00}) + K_W'(att_gain_q);
	assign k_rep = K_W'({rep_gain_q, 2'b00}) + K_W'(rep_gain_q);
	assign rq    = NB'({radius_q, F'(0)});

	// The pipeline moves whenever the output register is free or being taken.
	logic adv;
	assign adv      = !(out_valid && out_stall);
	assign in_stall = !adv;

	// Stage 1: absolute coordinate differences to goal and obstacle.
	logic          v_s1;
	logic [CW-1:0] dxa_s1, dya_s1, dxo_s1, dyo_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (adv) begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			dxa_s1 <= (point_x > goal_x_q) ? point_x - goal_x_q : goal_x_q - point_x;
			dya_s1 <= (point_y > goal_y_q) ? point_y - goal_y_q : goal_y_q - point_y;
			dxo_s1 <= (point_x > obst_x_q) ? point_x - obst_x_q : obst_x_q - point_x;
			dyo_s1 <= (point_y > obst_y_q) ? point_y - obst_y_q : obst_y_q - point_y;
		end
	end

	// Stage 2: squared distances, scaled up so the root comes out in Q.F.
	logic          v_s2;
	logic [SW-1:0] sum_a, sum_o;
	logic [RW-1:0] rad_s2 [pfe_pkg::LANES];

	assign sum_a = SW'(dxa_s1) * SW'(dxa_s1) + SW'(dya_s1) * SW'(dya_s1);
	assign sum_o = SW'(dxo_s1) * SW'(dxo_s1) + SW'(dyo_s1) * SW'(dyo_s1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (adv) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			rad_s2[0] <= RW'({sum_a, (2*F)'(0)});
			rad_s2[1] <= RW'({sum_o, (2*F)'(0)});
		end
	end

	// Square roots: lane 0 is the goal distance, lane 1 the obstacle distance.
	logic          v_sq;
	logic [NB-1:0] dist_sq [pfe_pkg::LANES];

	pfe_sqrt #(
		.NB (NB)
	) u_sqrt (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctl       ('{adv: adv, valid: v_s2}),
		.rad_in    (rad_s2),
		.valid_out (v_sq),
		.root_out  (dist_sq)
	);

	// Stage P: attractive result, range tests, divisor setup.
	logic             v_sp;
	logic [OW-1:0]    att_sp;
	logic             near_sp, zero_sp;
	logic [NB-1:0]    dvsr_sp [pfe_pkg::LANES];
	logic [ATT_X-1:0] att_full;

	assign att_full = (ATT_X'(k_att) * ATT_X'(dist_sq[0])) >> pfe_pkg::ATT_SHIFT;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_sp <= 1'b0;
		end else if (adv) begin
			v_sp <= v_sq;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			att_sp     <= (att_full > ATT_X'(pfe_pkg::OUT_MAX)) ? pfe_pkg::OUT_MAX
			                                                   : att_full[OW-1:0];
			near_sp    <= dist_sq[1] < rq;
			zero_sp    <= dist_sq[1] == '0;
			dvsr_sp[0] <= dist_sq[1];
			dvsr_sp[1] <= rq;
		end
	end

	// Reciprocals of the obstacle distance and of the radius, in Q.24.
	logic              v_dv;
	logic [QB-1:0]     recip [pfe_pkg::LANES];
	logic [SIDE_W-1:0] side_dv;

	pfe_div #(
		.DW     (NB),
		.QB     (QB),
		.SIDE_W (SIDE_W)
	) u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctl       ('{adv: adv, valid: v_sp}),
		.dvsr_in   (dvsr_sp),
		.side_in   ({att_sp, near_sp, zero_sp}),
		.valid_out (v_dv),
		.quot_out  (recip),
		.side_out  (side_dv)
	);

	// Stage D: reciprocal difference. Inside the radius it is below 2^DIFF_W.
	logic              v_sd;
	logic [DIFF_W-1:0] diff_sd;
	logic [SIDE_W-1:0] side_sd;
	logic [QB-1:0]     diff_full;

	assign diff_full = recip[0] - recip[1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_sd <= 1'b0;
		end else if (adv) begin
			v_sd <= v_dv;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			diff_sd <= diff_full[DIFF_W-1:0];
			side_sd <= side_dv;
		end
	end

	// Stage E: square of the difference.
	logic              v_se;
	logic [SQ_W-1:0]   sq_se;
	logic [SIDE_W-1:0] side_se;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_se <= 1'b0;
		end else if (adv) begin
			v_se <= v_sd;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			sq_se   <= SQ_W'(diff_sd) * SQ_W'(diff_sd);
			side_se <= side_sd;
		end
	end

	// Stage F: gain times the square, as two half-width partial products.
	logic              v_sf;
	logic [P_W-1:0]    plo_sf, phi_sf;
	logic [SIDE_W-1:0] side_sf;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_sf <= 1'b0;
		end else if (adv) begin
			v_sf <= v_se;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			plo_sf  <= P_W'(k_rep) * P_W'(sq_se[DIFF_W-1:0]);
			phi_sf  <= P_W'(k_rep) * P_W'(sq_se[SQ_W-1:DIFF_W]);
			side_sf <= side_se;
		end
	end

	// Stage G: combine the partial products, scale and saturate.
	logic             v_sg;
	logic [OW-1:0]    att_sg, rep_sg;
	logic             inf_sg;
	logic [ACC_W-1:0] acc, rep_full;
	logic [OW-1:0]    att_f;
	logic             near_f, zero_f;

	assign {att_f, near_f, zero_f} = side_sf;
	assign acc      = ACC_W'({phi_sf, DIFF_W'(0)}) + ACC_W'(plo_sf);
	assign rep_full = acc >> REP_SH;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_sg <= 1'b0;
		end else if (adv) begin
			v_sg <= v_sf;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			att_sg <= att_f;
			inf_sg <= near_f && zero_f;
			if (near_f && !zero_f) begin
				rep_sg <= (rep_full > ACC_W'(pfe_pkg::OUT_MAX)) ? pfe_pkg::OUT_MAX
				                                                : rep_full[OW-1:0];
			end else begin
				rep_sg <= '0;
			end
		end
	end

	// Output register: the total is formed here with its own saturation.
	logic [OW:0] total_full;
	assign total_full = {1'b0, att_sg} + {1'b0, rep_sg};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (adv) begin
			out_valid <= v_sg;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			attract_value    <= att_sg;
			repulse_value    <= rep_sg;
			repulse_infinite <= inf_sg;
			total_value      <= total_full[OW] ? pfe_pkg::OUT_MAX : total_full[OW-1:0];
		end
	end

	// A point on the obstacle contributes nothing to the repulsive or total value.
	a_inf_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && repulse_infinite |-> repulse_value == '0 &&
		total_value == attract_value)
		else $error("infinite flag with a nonzero repulsive contribution");

	// The total never falls below either of its parts.
	a_total_bound: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> total_value >= attract_value && total_value >= repulse_value)
		else $error("total below one of its parts");

	// Without overflow the total is the exact sum.
	a_total_sum: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && ({1'b0, attract_value} + {1'b0, repulse_value} <=
		{1'b0, pfe_pkg::OUT_MAX}) |->
		{1'b0, total_value} == {1'b0, attract_value} + {1'b0, repulse_value})
		else $error("total differs from the sum of its parts");

	// Backpressure comes only from a result held at the output.
	a_stall_src: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid)
		else $error("input stalled with an empty output register");

endmodule

// File: rtl/pfe_sqrt.sv
// Two-lane pipelined integer square root, one result bit per stage.
// Depends on pfe_pkg for the control struct and lane count.
module pfe_sqrt #(
	parameter int NB = 21
) (
	input  logic                clk,
	input  logic                arst_n,
	input  pfe_pkg::pipe_ctl_t  ctl,
	input  logic [2*NB-1:0]     rad_in [pfe_pkg::LANES],
	output logic                valid_out,
	output logic [NB-1:0]       root_out [pfe_pkg::LANES]
);

	logic [2*NB-1:0] rad_st  [NB+1][pfe_pkg::LANES];
	logic [NB+1:0]   rem_st  [NB+1][pfe_pkg::LANES];
	logic [NB-1:0]   root_st [NB+1][pfe_pkg::LANES];
	logic            vld_st  [NB+1];

	assign vld_st[0] = ctl.valid;

	for (genvar l = 0; l < pfe_pkg::LANES; l++) begin : g_in
		assign rad_st[0][l]  = rad_in[l];
		assign rem_st[0][l]  = '0;
		assign root_st[0][l] = '0;
		assign root_out[l]   = root_st[NB][l];
	end

	for (genvar i = 0; i < NB; i++) begin : g_stage
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_st[i+1] <= 1'b0;
			end else if (ctl.adv) begin
				vld_st[i+1] <= vld_st[i];
			end
		end

		for (genvar l = 0; l < pfe_pkg::LANES; l++) begin : g_lane
			logic [NB+1:0] rem_sh;
			logic [NB+1:0] trial;
			logic          ge;

			// Bring down the next two radicand bits and try root*4+1.
			assign rem_sh = {rem_st[i][l][NB-1:0], rad_st[i][l][2*NB-1 -: 2]};
			assign trial  = {root_st[i][l], 2'b01};
			assign ge     = rem_sh >= trial;

			always_ff @(posedge clk) begin
				if (ctl.adv) begin
					rad_st[i+1][l]  <= {rad_st[i][l][2*NB-3:0], 2'b00};
					rem_st[i+1][l]  <= ge ? rem_sh - trial : rem_sh;
					root_st[i+1][l] <= {root_st[i][l][NB-2:0], ge};
				end
			end
		end
	end

	assign valid_out = vld_st[NB];

endmodule

// File: rtl/pfe_div.sv
// Two-lane pipelined restoring divider that forms 2^(QB-1) / divisor,
// one quotient bit per stage, with a sideband carried alongside.
// Depends on pfe_pkg for the control struct and lane count.
module pfe_div #(
	parameter int DW     = 21,
	parameter int QB     = 33,
	parameter int SIDE_W = 30
) (
	input  logic                clk,
	input  logic                arst_n,
	input  pfe_pkg::pipe_ctl_t  ctl,
	input  logic [DW-1:0]       dvsr_in [pfe_pkg::LANES],
	input  logic [SIDE_W-1:0]   side_in,
	output logic                valid_out,
	output logic [QB-1:0]       quot_out [pfe_pkg::LANES],
	output logic [SIDE_W-1:0]   side_out
);

	logic [DW-1:0]     dv_st   [QB+1][pfe_pkg::LANES];
	logic [DW-1:0]     rem_st  [QB+1][pfe_pkg::LANES];
	logic [QB-1:0]     quot_st [QB+1][pfe_pkg::LANES];
	logic [SIDE_W-1:0] side_st [QB+1];
	logic              vld_st  [QB+1];

	assign vld_st[0]  = ctl.valid;
	assign side_st[0] = side_in;

	for (genvar l = 0; l < pfe_pkg::LANES; l++) begin : g_in
		assign dv_st[0][l]   = dvsr_in[l];
		assign rem_st[0][l]  = '0;
		assign quot_st[0][l] = '0;
		assign quot_out[l]   = quot_st[QB][l];
	end

	for (genvar i = 0; i < QB; i++) begin : g_stage
		// The dividend is a single one in its top bit.
		localparam logic NUM_BIT = (i == 0);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_st[i+1] <= 1'b0;
			end else if (ctl.adv) begin
				vld_st[i+1] <= vld_st[i];
			end
		end

		always_ff @(posedge clk) begin
			if (ctl.adv) begin
				side_st[i+1] <= side_st[i];
			end
		end

		for (genvar l = 0; l < pfe_pkg::LANES; l++) begin : g_lane
			logic [DW:0]   rem_sh;
			logic [DW:0]   rem_sub;
			logic          ge;

			assign rem_sh  = {rem_st[i][l], NUM_BIT};
			assign ge      = rem_sh >= {1'b0, dv_st[i][l]};
			assign rem_sub = rem_sh - {1'b0, dv_st[i][l]};

			always_ff @(posedge clk) begin
				if (ctl.adv) begin
					dv_st[i+1][l]   <= dv_st[i][l];
					rem_st[i+1][l]  <= ge ? rem_sub[DW-1:0] : rem_sh[DW-1:0];
					quot_st[i+1][l] <= {quot_st[i][l][QB-2:0], ge};
				end
			end
		end
	end

	assign valid_out = vld_st[QB];
	assign side_out  = side_st[QB];

endmodule
